FILE: rtl/core/sli_pkg.sv
// package for the sorted list insert/remove block
// shared constants, controller states, datapath operations, status codes and flags struct
// no dependencies
package sli_pkg;

    localparam int SLI_CAPACITY = 16;
    localparam int SLI_DATA_W   = 32;
    localparam int SLI_COUNT_W  = 5;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } sli_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_CHK,
        S_INS_CMP,
        S_REM_CHK,
        S_REM_CMP,
        S_SHF_CHK,
        S_SHF_WR,
        S_LO,
        S_HI,
        S_CAP,
        S_OUT
    } sli_state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SET_FULL,
        OP_SET_MISS,
        OP_INS_RD,
        OP_INS_SHIFT,
        OP_INS_PUT,
        OP_REM_RD,
        OP_IDX_INC,
        OP_SHF_RD,
        OP_SHF_STEP,
        OP_REM_DONE,
        OP_RD_LO,
        OP_RD_HI,
        OP_CAP_HI,
        OP_EMIT
    } sli_op_t;

    typedef struct packed {
        logic is_remove;
        logic full;
        logic idx_zero;
        logic idx_end;
        logic shf_last;
        logic ins_ge;
        logic rem_hit;
        logic out_free;
    } sli_flags_t;

endpackage

FILE: rtl/core/sli_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/sli_ctrl.sv
// controller state machine for the sorted list block
// depends on sli_pkg; drives datapath operations from datapath flags
module sli_ctrl
    import sli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sli_flags_t flags,
    output sli_op_t    op
);

    sli_state_t state_reg;
    sli_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NOP;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (flags.is_remove)
                begin
                    state_next = S_REM_CHK;
                end
                else if (flags.full)
                begin
                    op         = OP_SET_FULL;
                    state_next = S_LO;
                end
                else
                begin
                    state_next = S_INS_CHK;
                end
            end
            S_INS_CHK:
            begin
                if (flags.idx_zero)
                begin
                    op         = OP_INS_PUT;
                    state_next = S_LO;
                end
                else
                begin
                    op         = OP_INS_RD;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (flags.ins_ge)
                begin
                    op         = OP_INS_SHIFT;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    op         = OP_INS_PUT;
                    state_next = S_LO;
                end
            end
            S_REM_CHK:
            begin
                if (flags.idx_end)
                begin
                    op         = OP_SET_MISS;
                    state_next = S_LO;
                end
                else
                begin
                    op         = OP_REM_RD;
                    state_next = S_REM_CMP;
                end
            end
            S_REM_CMP:
            begin
                if (flags.rem_hit)
                begin
                    state_next = S_SHF_CHK;
                end
                else
                begin
                    op         = OP_IDX_INC;
                    state_next = S_REM_CHK;
                end
            end
            S_SHF_CHK:
            begin
                if (flags.shf_last)
                begin
                    op         = OP_REM_DONE;
                    state_next = S_LO;
                end
                else
                begin
                    op         = OP_SHF_RD;
                    state_next = S_SHF_WR;
                end
            end
            S_SHF_WR:
            begin
                op         = OP_SHF_STEP;
                state_next = S_SHF_CHK;
            end
            S_LO:
            begin
                op         = OP_RD_LO;
                state_next = S_HI;
            end
            S_HI:
            begin
                op         = OP_RD_HI;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                op         = OP_CAP_HI;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (flags.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/sli_dp.sv
// datapath for the sorted list block: entry ram, index, count and result register
// depends on sli_pkg and sli_ram
module sli_dp
    import sli_pkg::*;
#(
    parameter int CAPACITY = SLI_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sli_op_t                       op,
    output sli_flags_t                    flags,
    input  logic                          action,
    input  logic signed [SLI_DATA_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [SLI_COUNT_W-1:0]        count,
    output logic signed [SLI_DATA_W-1:0]  smallest,
    output logic signed [SLI_DATA_W-1:0]  largest
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [SLI_DATA_W-1:0] val_reg;
    logic                         act_reg;
    logic [CW-1:0]                idx_reg;
    logic [CW-1:0]                cnt_reg;
    sli_status_t                  stat_reg;
    logic signed [SLI_DATA_W-1:0] lo_reg;
    logic signed [SLI_DATA_W-1:0] hi_reg;
    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [SLI_COUNT_W-1:0]       count_reg;
    logic signed [SLI_DATA_W-1:0] smallest_reg;
    logic signed [SLI_DATA_W-1:0] largest_reg;

    logic [CW-1:0]                idx_dec;
    logic [CW-1:0]                idx_inc;
    logic [CW-1:0]                cnt_dec;
    logic                         we;
    logic [AW-1:0]                waddr;
    logic [SLI_DATA_W-1:0]        wdata;
    logic [AW-1:0]                raddr;
    logic [SLI_DATA_W-1:0]        rdata;

    assign idx_dec = idx_reg - CW'(1);
    assign idx_inc = idx_reg + CW'(1);
    assign cnt_dec = cnt_reg - CW'(1);

    sli_ram #(
        .WIDTH (SLI_DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = val_reg;
        raddr = idx_reg[AW-1:0];
        case (op)
            OP_INS_RD:    raddr = idx_dec[AW-1:0];
            OP_INS_SHIFT:
            begin
                we    = 1'b1;
                wdata = rdata;
            end
            OP_INS_PUT:   we = 1'b1;
            OP_SHF_RD:    raddr = idx_inc[AW-1:0];
            OP_SHF_STEP:
            begin
                we    = 1'b1;
                wdata = rdata;
            end
            OP_RD_LO:     raddr = '0;
            OP_RD_HI:     raddr = cnt_dec[AW-1:0];
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        flags.is_remove = act_reg;
        flags.full      = (cnt_reg == CW'(CAPACITY));
        flags.idx_zero  = (idx_reg == '0);
        flags.idx_end   = (idx_reg == cnt_reg);
        flags.shf_last  = (idx_inc >= cnt_reg);
        flags.ins_ge    = ($signed(rdata) >= val_reg);
        flags.rem_hit   = (rdata == val_reg);
        flags.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                OP_INS_PUT:  cnt_reg <= cnt_reg + CW'(1);
                OP_REM_DONE: cnt_reg <= cnt_dec;
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                val_reg  <= value;
                act_reg  <= action;
                idx_reg  <= action ? '0 : cnt_reg;
                stat_reg <= ST_DONE;
            end
            OP_SET_FULL:  stat_reg <= ST_FULL;
            OP_SET_MISS:  stat_reg <= ST_MISS;
            OP_INS_SHIFT: idx_reg  <= idx_dec;
            OP_IDX_INC:   idx_reg  <= idx_inc;
            OP_SHF_STEP:  idx_reg  <= idx_inc;
            OP_RD_HI:     lo_reg   <= rdata;
            OP_CAP_HI:    hi_reg   <= rdata;
            OP_EMIT:
            begin
                status_reg   <= stat_reg;
                count_reg    <= SLI_COUNT_W'(cnt_reg);
                smallest_reg <= (cnt_reg == '0) ? '0 : lo_reg;
                largest_reg  <= (cnt_reg == '0) ? '0 : hi_reg;
            end
            default:
            begin
                val_reg <= val_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign smallest  = smallest_reg;
    assign largest   = largest_reg;

endmodule

FILE: rtl/core/sorted_list_insert_remove.sv
// Keeps up to CAPACITY signed 32-bit values in ascending order in a single-port-read RAM,
// duplicates allowed. An insert (action 0) walks down from the top, moving every entry not
// smaller than the value up one place, then writes the value; a remove (action 1) walks up
// to the first equal entry and moves the entries above it down one place. Each beat returns
// status (0 done, 1 full, 2 not found), the count and the smallest and largest entries (0
// when empty). One item is handled at a time; every visited entry takes a read step and a
// compare or write step because the RAM read is registered, and every item also passes
// through the accept, the opening check, the end reads and the result register, with a
// closing check at the end of a walk. The next item is taken while a result waits.
module sorted_list_insert_remove
    import sli_pkg::*;
#(
    parameter int CAPACITY = SLI_CAPACITY
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         action,
    input  logic signed [SLI_DATA_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [SLI_COUNT_W-1:0]       count,
    output logic signed [SLI_DATA_W-1:0] smallest,
    output logic signed [SLI_DATA_W-1:0] largest
);

    sli_flags_t flags;
    sli_op_t    op;

    sli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .flags    (flags),
        .op       (op)
    );

    sli_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .flags     (flags),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .count     (count),
        .smallest  (smallest),
        .largest   (largest)
    );

endmodule
